[hdl/kdpq_pkg.sv]
package kdpq_pkg;

  // fixed field widths of the channels
  localparam int PKT_TAG_W = 32;
  localparam int OCC_W     = 9;
  localparam int MAXLEN_W  = 8;

  // defaults of the top level parameters
  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int TAG_BITS_DEF    = 32;

  // limit after reset
  localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = 8'd100;

  // request operations
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_DROP,
    S_EMIT
  } state_t;

endpackage

[hdl/kdpq_req_if.sv]
interface kdpq_req_if
  import kdpq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  op_t                  operation;
  logic [PKT_TAG_W-1:0] packet_tag;
  logic                 key_flag;

  modport source (output valid, output operation, output packet_tag, output key_flag,
                  input ready);
  modport sink   (input valid, input operation, input packet_tag, input key_flag,
                  output ready);
endinterface

[hdl/kdpq_res_if.sv]
interface kdpq_res_if
  import kdpq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 pop_valid;
  logic [PKT_TAG_W-1:0] pop_tag;
  logic                 pop_key;
  logic [OCC_W-1:0]     dropped_count;
  logic                 push_rejected;
  logic [OCC_W-1:0]     occupancy;

  modport source (output valid, output pop_valid, output pop_tag, output pop_key,
                  output dropped_count, output push_rejected, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_valid, input pop_tag, input pop_key,
                  input dropped_count, input push_rejected, input occupancy,
                  output ready);
endinterface

[hdl/keyframe_drop_packet_queue_top.sv]
// Bounded queue of packet descriptors (tag plus keyframe flag) that drops
// from the head down to the next keyframe when a push overfills it.
// Requests arrive on in_req (valid/ready): push, pop, clear or no-op.
// Every request gives exactly one result on out_res (valid/ready) with the
// popped entry, the entries dropped, a rejected-push flag and the occupancy.
// cfg_wr_en/cfg_wr_data set the queue length limit; write only when idle.
// A request is taken in the idle state; a pop then reads its entry in
// S_POP, and a push that overfills the queue drops in S_DROP, walking the
// head through the key memory one read per cycle; each result goes from
// S_EMIT into the output register.
// Tags and keyframe flags sit in two single-port-read memories with a
// registered read; the key of a push into an empty queue is forwarded from
// the request.
// The output register lets the next request be taken while a result waits;
// if the receiver stalls, the following result holds in its final state
// until the output register is free.
// Reset (synchronous, active low) empties the queue and sets the limit to
// 100; memory contents are not cleared and are never read before written.
module keyframe_drop_packet_queue_top
  import kdpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  kdpq_req_if.sink            in_req,
  kdpq_res_if.source          out_res,
  input  logic                cfg_wr_en,
  input  logic [MAXLEN_W-1:0] cfg_wr_data
);

  localparam int IW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = (CW > MAXLEN_W) ? CW : MAXLEN_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  // storage
  logic [TAG_BITS-1:0] tag_mem [QUEUE_DEPTH];
  logic                key_mem [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tag_q;
  logic                key_q;
  logic [IW-1:0]       rd_addr;
  logic                mem_we;

  // control and working registers
  state_t              state_r, state_nxt;
  logic [IW-1:0]       head_r, head_nxt;
  logic [IW-1:0]       tail_r, tail_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [MAXLEN_W-1:0] max_len_r;
  logic                fwd_valid_r, fwd_valid_nxt;
  logic                fwd_key_r, fwd_key_nxt;
  logic                res_pop_valid_r, res_pop_valid_nxt;
  logic [TAG_BITS-1:0] res_pop_tag_r, res_pop_tag_nxt;
  logic                res_pop_key_r, res_pop_key_nxt;
  logic [CW-1:0]       res_dropped_r, res_dropped_nxt;
  logic                res_rejected_r, res_rejected_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic                 out_pop_valid_r;
  logic [PKT_TAG_W-1:0] out_pop_tag_r;
  logic                 out_pop_key_r;
  logic [OCC_W-1:0]     out_dropped_r;
  logic                 out_rejected_r;
  logic [OCC_W-1:0]     out_occ_r;

  // width adaption
  logic [TAG_BITS+PKT_TAG_W-1:0] tag_in_ext;
  logic [TAG_BITS-1:0]           wr_tag;
  logic [TAG_BITS+PKT_TAG_W-1:0] tag_out_ext;
  logic [CW+OCC_W-1:0]           dropped_ext;
  logic [CW+OCC_W-1:0]           occ_ext;
  logic [CMPW-1:0]               cnt_inc_cmp;
  logic [CMPW-1:0]               max_cmp;
  logic [CW-1:0]                 cnt_inc;
  logic                          key_now;
  logic                          out_free;

  assign tag_in_ext  = {{TAG_BITS{1'b0}}, in_req.packet_tag};
  assign wr_tag      = tag_in_ext[TAG_BITS-1:0];
  assign tag_out_ext = {{PKT_TAG_W{1'b0}}, res_pop_tag_r};
  assign dropped_ext = {{OCC_W{1'b0}}, res_dropped_r};
  assign occ_ext     = {{OCC_W{1'b0}}, count_r};
  assign cnt_inc     = count_r + ONE_CNT;
  assign cnt_inc_cmp = CMPW'(cnt_inc);
  assign max_cmp     = CMPW'(max_len_r);
  assign key_now     = fwd_valid_r ? fwd_key_r : key_q;
  assign out_free    = !out_valid_r || out_res.ready;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
    next_idx = (idx == LAST_IDX) ? '0 : idx + IW'(1);
  endfunction

  // memories: write at tail, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[tail_r] <= wr_tag;
      key_mem[tail_r] <= in_req.key_flag;
    end
    tag_q <= tag_mem[rd_addr];
    key_q <= key_mem[rd_addr];
  end

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    fwd_key_r       <= fwd_key_nxt;
    res_pop_valid_r <= res_pop_valid_nxt;
    res_pop_tag_r   <= res_pop_tag_nxt;
    res_pop_key_r   <= res_pop_key_nxt;
    res_dropped_r   <= res_dropped_nxt;
    res_rejected_r  <= res_rejected_nxt;
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pop_valid_r <= res_pop_valid_r;
      out_pop_tag_r   <= tag_out_ext[PKT_TAG_W-1:0];
      out_pop_key_r   <= res_pop_key_r;
      out_dropped_r   <= dropped_ext[OCC_W-1:0];
      out_rejected_r  <= res_rejected_r;
      out_occ_r       <= occ_ext[OCC_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    head_nxt          = head_r;
    tail_nxt          = tail_r;
    count_nxt         = count_r;
    fwd_valid_nxt     = fwd_valid_r;
    fwd_key_nxt       = fwd_key_r;
    res_pop_valid_nxt = res_pop_valid_r;
    res_pop_tag_nxt   = res_pop_tag_r;
    res_pop_key_nxt   = res_pop_key_r;
    res_dropped_nxt   = res_dropped_r;
    res_rejected_nxt  = res_rejected_r;
    rd_addr           = head_r;
    mem_we            = 1'b0;
    out_load          = 1'b0;
    out_valid_nxt     = out_valid_r && !out_res.ready;
    in_req.ready      = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          res_pop_valid_nxt = 1'b0;
          res_pop_tag_nxt   = '0;
          res_pop_key_nxt   = 1'b0;
          res_dropped_nxt   = '0;
          res_rejected_nxt  = 1'b0;
          state_nxt         = S_EMIT;
          case (in_req.operation)
            OP_PUSH: begin
              if (count_r == FULL_CNT) begin
                res_rejected_nxt = 1'b1;
              end else begin
                mem_we    = 1'b1;
                tail_nxt  = next_idx(tail_r);
                count_nxt = cnt_inc;
                // head read starts now; an empty queue forwards the new key
                if (cnt_inc_cmp > max_cmp) begin
                  fwd_valid_nxt = (count_r == '0);
                  fwd_key_nxt   = in_req.key_flag;
                  state_nxt     = S_DROP;
                end
              end
            end
            OP_POP: begin
              if (count_r != '0) begin
                res_pop_valid_nxt = 1'b1;
                head_nxt          = next_idx(head_r);
                count_nxt         = count_r - ONE_CNT;
                state_nxt         = S_POP;
              end
            end
            OP_CLEAR: begin
              res_dropped_nxt = count_r;
              count_nxt       = '0;
              head_nxt        = tail_r;
            end
            default: begin
            end
          endcase
        end
      end

      // capture popped entry
      S_POP: begin
        res_pop_tag_nxt = tag_q;
        res_pop_key_nxt = key_q;
        state_nxt       = S_EMIT;
      end

      // one head entry checked per cycle, next read issued ahead
      S_DROP: begin
        fwd_valid_nxt = 1'b0;
        rd_addr       = next_idx(head_r);
        if (key_now) begin
          state_nxt = S_EMIT;
        end else begin
          head_nxt        = next_idx(head_r);
          count_nxt       = count_r - ONE_CNT;
          res_dropped_nxt = res_dropped_r + ONE_CNT;
          if (count_r == ONE_CNT) begin
            state_nxt = S_EMIT;
          end
        end
      end

      // hand result to the output register when it is free
      S_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.pop_valid     = out_pop_valid_r;
  assign out_res.pop_tag       = out_pop_tag_r;
  assign out_res.pop_key       = out_pop_key_r;
  assign out_res.dropped_count = out_dropped_r;
  assign out_res.push_rejected = out_rejected_r;
  assign out_res.occupancy     = out_occ_r;

endmodule

[bench/kdpq_checker.sv]
`timescale 1ns / 1ps

module kdpq_checker
  import kdpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  kdpq_req_if                 req,
  kdpq_res_if                 res,
  input  logic                cfg_wr_en,
  input  logic [MAXLEN_W-1:0] cfg_wr_data,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic                 pop_valid;
    logic [PKT_TAG_W-1:0] pop_tag;
    logic                 pop_key;
    logic [OCC_W-1:0]     dropped_count;
    logic                 push_rejected;
    logic [OCC_W-1:0]     occupancy;
  } queue_result_t;

  // shadow copy of the descriptor queue
  logic [PKT_TAG_W-1:0] tag_mem [QUEUE_DEPTH];
  logic                 key_mem [QUEUE_DEPTH];
  int unsigned          head_ptr;
  int unsigned          tail_ptr;
  int unsigned          held;
  logic [MAXLEN_W-1:0]  length_limit;

  queue_result_t awaited_results [$];
  int            results_seen;

  // apply one request to the shadow queue and return the result it must give
  function automatic queue_result_t predict_queue_step(input op_t op,
                                                       input logic [PKT_TAG_W-1:0] tag,
                                                       input logic key);
    queue_result_t r;
    int unsigned   dropped;
    r       = '0;
    dropped = 0;
    case (op)
      OP_PUSH: begin
        if (held >= QUEUE_DEPTH) begin
          r.push_rejected = 1'b1;
        end else begin
          tag_mem[tail_ptr] = tag;
          key_mem[tail_ptr] = key;
          tail_ptr = (tail_ptr + 1) % QUEUE_DEPTH;
          held++;
          // overfilled: walk the head forward up to the next keyframe
          if (held > length_limit) begin
            while (held > 0 && !key_mem[head_ptr]) begin
              head_ptr = (head_ptr + 1) % QUEUE_DEPTH;
              held--;
              dropped++;
            end
          end
        end
      end
      OP_POP: begin
        if (held > 0) begin
          r.pop_valid = 1'b1;
          r.pop_tag   = tag_mem[head_ptr];
          r.pop_key   = key_mem[head_ptr];
          head_ptr = (head_ptr + 1) % QUEUE_DEPTH;
          held--;
        end
      end
      OP_CLEAR: begin
        dropped  = held;
        held     = 0;
        head_ptr = tail_ptr;
      end
      default: ;
    endcase
    r.dropped_count = OCC_W'(dropped);
    r.occupancy     = OCC_W'(held);
    return r;
  endfunction

  // watch both channels: predict on each request, compare on each result
  always @(posedge clk) begin : watch_channels
    queue_result_t want;
    queue_result_t got;
    if (!rst_n) begin
      head_ptr     = 0;
      tail_ptr     = 0;
      held         = 0;
      length_limit = MAX_LEN_RESET;
      results_seen = 0;
      fail_count   = 0;
      awaited_results.delete();
    end else begin
      if (cfg_wr_en) length_limit = cfg_wr_data;
      if (res.valid && res.ready) begin
        got = '{res.pop_valid, res.pop_tag, res.pop_key, res.dropped_count,
                res.push_rejected, res.occupancy};
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d arrived with no request outstanding", results_seen);
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result %0d mismatch", results_seen);
              $display("  expected pv=%b tag=%h key=%b drop=%0d rej=%b occ=%0d",
                       want.pop_valid, want.pop_tag, want.pop_key, want.dropped_count,
                       want.push_rejected, want.occupancy);
              $display("  actual   pv=%b tag=%h key=%b drop=%0d rej=%b occ=%0d",
                       got.pop_valid, got.pop_tag, got.pop_key, got.dropped_count,
                       got.push_rejected, got.occupancy);
            end
          end
        end
        results_seen++;
      end
      if (req.valid && req.ready)
        awaited_results.insert(awaited_results.size(),
                               predict_queue_step(req.operation, req.packet_tag,
                                                  req.key_flag));
    end
    pending <= awaited_results.size();
  end

endmodule

[bench/keyframe_drop_packet_queue_top_tb.sv]
`timescale 1ns / 1ps

module keyframe_drop_packet_queue_top_tb;
  import kdpq_pkg::*;

  localparam int DEPTH          = QUEUE_DEPTH_DEF;
  localparam int STIMULUS_ITEMS = 930;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF       = 300;
  localparam int SETTLE_CYCLES  = 8;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [MAXLEN_W-1:0] cfg_wr_data;
  int                  fail_count;
  int                  pending;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int quiet_cycles   = 0;
  int sent           = 0;

  kdpq_req_if in_req ();
  kdpq_res_if out_res ();

  keyframe_drop_packet_queue_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .out_res     (out_res),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  kdpq_checker #(
    .QUEUE_DEPTH (DEPTH)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (in_req),
    .res         (out_res),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always #1 clk = ~clk;

  // result side: random stalls, plus a long hold-off when one is asked for
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_OFF;
        out_res.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one request, with random idle cycles ahead of it
  task automatic send_request(input op_t op, input logic [PKT_TAG_W-1:0] tag,
                              input logic key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid      <= 1'b1;
    in_req.operation  <= op;
    in_req.packet_tag <= tag;
    in_req.key_flag   <= key;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    sent++;
  endtask

  // wait until every result is back and the block has settled
  task automatic wait_drained();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [MAXLEN_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic set_phase(input int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
      1: begin send_idle_pct = 47; recv_stall_pct <= 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct <= 47; end
      default: begin send_idle_pct = 32; recv_stall_pct <= 32; end
    endcase
  endtask

  // mostly pushes so the queue grows and hits its limit
  task automatic random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 58)      send_request(OP_PUSH, $urandom, $urandom_range(99) < 25);
    else if (pick < 86) send_request(OP_POP, $urandom, 1'($urandom_range(1)));
    else if (pick < 93) send_request(OP_NOP, $urandom, 1'($urandom_range(1)));
    else                send_request(OP_CLEAR, $urandom, 1'($urandom_range(1)));
  endtask

  function automatic logic [MAXLEN_W-1:0] pick_limit();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 8'd1;
      2:       return 8'hFF;
      3:       return MAXLEN_W'($urandom_range(255));
      default: return MAXLEN_W'($urandom_range(2, 12));
    endcase
  endfunction

  // fill the whole store; a keyframe at the head keeps it from dropping
  task automatic fill_store(input logic head_key);
    send_request(OP_CLEAR, $urandom, 1'b0);
    send_request(OP_PUSH, $urandom, head_key);
    repeat (DEPTH - 1)
      send_request(OP_PUSH, $urandom, head_key ? 1'($urandom_range(1)) : 1'b0);
    send_request(OP_PUSH, $urandom, 1'b1);
    send_request(OP_PUSH, $urandom, 1'b0);
    send_request(OP_POP, $urandom, 1'b0);
    send_request(OP_PUSH, $urandom, 1'b0);
    send_request(OP_CLEAR, $urandom, 1'b0);
  endtask

  initial begin : stimulus
    int episode;
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    in_req.valid      <= 1'b0;
    in_req.operation  <= OP_NOP;
    in_req.packet_tag <= '0;
    in_req.key_flag   <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, tag extremes, every operation at the reset limit
    send_request(OP_POP, 32'h0, 1'b0);
    send_request(OP_CLEAR, 32'h0, 1'b0);
    send_request(OP_NOP, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_PUSH, 32'h0, 1'b0);
    send_request(OP_PUSH, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_PUSH, 32'hAAAA_AAAA, 1'b0);
    send_request(OP_NOP, 32'h0, 1'b0);
    send_request(OP_POP, 32'h0, 1'b0);
    send_request(OP_POP, 32'h0, 1'b0);
    send_request(OP_CLEAR, 32'h0, 1'b0);

    // small limit: drop empties the queue, keyframe head blocks the drop
    set_limit(8'd2);
    send_request(OP_PUSH, 32'h1111_0001, 1'b0);
    send_request(OP_PUSH, 32'h1111_0002, 1'b0);
    send_request(OP_PUSH, 32'h1111_0003, 1'b0);
    send_request(OP_PUSH, 32'h2222_0001, 1'b1);
    send_request(OP_PUSH, 32'h2222_0002, 1'b0);
    send_request(OP_PUSH, 32'h2222_0003, 1'b0);
    send_request(OP_POP, 32'h0, 1'b0);
    send_request(OP_PUSH, 32'h2222_0004, 1'b0);

    // zero limit: every accepted push tries to drop
    set_limit(8'd0);
    send_request(OP_PUSH, 32'h3333_0001, 1'b1);
    send_request(OP_PUSH, 32'h3333_0002, 1'b0);
    send_request(OP_POP, 32'h0, 1'b0);
    send_request(OP_PUSH, 32'h5555_5555, 1'b0);
    send_request(OP_PUSH, 32'h3333_0003, 1'b1);
    send_request(OP_CLEAR, 32'h0, 1'b0);

    // full store with rejected pushes, then a drop of every entry
    set_limit(8'hFF);
    set_phase(3);
    fill_store(1'b1);
    set_phase(1);
    fill_store(1'b0);

    // receiver holds off while requests keep coming
    set_limit(8'd6);
    set_phase(0);
    hold_asked <= hold_asked + 1;
    repeat (30) random_request();

    // random episodes under changing limits and idling
    episode = 0;
    while (sent < STIMULUS_ITEMS) begin
      set_limit(pick_limit());
      set_phase(episode);
      repeat ($urandom_range(20, 60)) random_request();
      episode++;
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
